// File: rtl/ssp_pkg.sv
// ----------------------------------------------------------------------------
// Shortest path package
// Shared constants, field widths, state types and control structs.
// ----------------------------------------------------------------------------
package ssp_pkg;

	localparam int DIST_W       = 20;
	localparam int NODE_FIELD_W = 4;
	localparam int COST_FIELD_W = 16;
	localparam int MODE_W       = 2;
	localparam int IN_TDATA_W   = 24;
	localparam int OUT_TDATA_W  = 32;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RUN   = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RELAX,
		ST_OUT_RD,
		ST_OUT_LD,
		ST_OUT_WAIT
	} ssp_state_t;

	typedef enum logic [1:0] {
		ES_SWEEP,
		ES_IDLE,
		ES_ADD_RD,
		ES_ADD_WR
	} es_state_t;

	typedef struct packed {
		logic clear;
		logic add;
	} edge_cmd_t;

endpackage

// File: rtl/ssp_edge_store.sv
// ----------------------------------------------------------------------------
// Edge cost store
// Cost matrix in a single-port-write memory with a present bit per entry.
// Handles the clearing sweep and the keep-the-smaller edge merge.
// ----------------------------------------------------------------------------
module ssp_edge_store #(
	parameter int MAX_NODES = 16,
	parameter int COST_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ssp_pkg::edge_cmd_t            cmd,
	input  logic [$clog2(MAX_NODES)-1:0]  wr_row,
	input  logic [$clog2(MAX_NODES)-1:0]  wr_col,
	input  logic [COST_BITS-1:0]          wr_cost,
	input  logic [$clog2(MAX_NODES)-1:0]  rd_row,
	input  logic [$clog2(MAX_NODES)-1:0]  rd_col,
	output logic                          busy,
	output logic                          rd_present,
	output logic [COST_BITS-1:0]          rd_cost
);
	import ssp_pkg::*;

	localparam int NW    = $clog2(MAX_NODES);
	localparam int AW    = 2 * NW;
	localparam int DEPTH = 1 << AW;
	localparam int EW    = COST_BITS + 1;

	es_state_t            state_q, state_nx;
	logic [AW-1:0]        sweep_q;
	logic [AW-1:0]        add_addr_q;
	logic [COST_BITS-1:0] add_cost_q;
	logic [EW-1:0]        mem [DEPTH];
	logic [EW-1:0]        rd_q;
	logic [AW-1:0]        raddr;
	logic                 we;
	logic [AW-1:0]        waddr;
	logic [EW-1:0]        wdata;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ES_SWEEP: begin
				if (sweep_q == '1) state_nx = ES_IDLE;
			end
			ES_IDLE: begin
				if (cmd.clear) state_nx = ES_SWEEP;
				else if (cmd.add) state_nx = ES_ADD_RD;
			end
			ES_ADD_RD: state_nx = ES_ADD_WR;
			ES_ADD_WR: state_nx = ES_IDLE;
			default: state_nx = ES_IDLE;
		endcase
	end

	always_comb begin
		busy  = 1'b1;
		we    = 1'b0;
		waddr = add_addr_q;
		wdata = {1'b1, add_cost_q};
		raddr = {rd_row, rd_col};
		case (state_q)
			ES_SWEEP: begin
				we    = 1'b1;
				waddr = sweep_q;
				wdata = '0;
			end
			ES_IDLE: begin
				busy = 1'b0;
			end
			ES_ADD_RD: begin
				raddr = add_addr_q;
			end
			ES_ADD_WR: begin
				we = !rd_q[EW-1] || (add_cost_q < rd_q[COST_BITS-1:0]);
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ES_SWEEP;
			sweep_q <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == ES_SWEEP) sweep_q <= sweep_q + 1'b1;
			else sweep_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ES_IDLE && cmd.add) begin
			add_addr_q <= {wr_row, wr_col};
			add_cost_q <= wr_cost;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	assign rd_present = rd_q[EW-1];
	assign rd_cost    = rd_q[COST_BITS-1:0];

endmodule

// File: rtl/single_source_shortest_path.sv
// ----------------------------------------------------------------------------
// Single-source shortest path engine
// Dijkstra over a cost matrix with one shared relax-and-select unit.
//
// The slave stream carries one command per transfer; tuser selects clear,
// add edge or run. Clear and add edge give no output. A run produces
// MAX_NODES transfers on the master stream in node order, with the
// reachable flag on tuser and tlast on the final node.
// Each settled node costs one pass through the relax unit, which relaxes the
// node's edges and selects the next node in the same pass; a run makes one
// pass per reachable node. Each result is then read, loaded and offered on
// the master stream. An edge add reads the stored entry and writes it back
// when no edge was present or the new cost is smaller. A clear sweeps all
// 2**(2*clog2(MAX_NODES)) entries of the cost memory (256 for 16 nodes),
// one entry a cycle. After reset the same sweep runs before s_tready rises.
// When the sink stalls, the current result is held and the engine waits;
// no new command is taken until the last result has been transferred.
// ----------------------------------------------------------------------------
module single_source_shortest_path #(
	parameter int MAX_NODES = 16,
	parameter int COST_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// from_node [3:0], to_node [7:4], edge_cost [23:8]
	input  logic [ssp_pkg::IN_TDATA_W-1:0]   s_tdata,
	// mode [1:0]
	input  logic [ssp_pkg::MODE_W-1:0]       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// node_id [3:0], distance [23:4], predecessor [27:24], zero [31:28]
	output logic [ssp_pkg::OUT_TDATA_W-1:0]  m_tdata,
	// reachable [0]
	output logic                             m_tuser,
	output logic                             m_tlast
);
	import ssp_pkg::*;

	localparam int NW  = $clog2(MAX_NODES);
	localparam int CW  = NW + 1;
	localparam int SW  = ((COST_BITS > DIST_W) ? COST_BITS : DIST_W) + 1;
	localparam int DMW = DIST_W + NW;

	ssp_state_t                    state_q, state_nx;
	logic                          accept;
	logic [NODE_FIELD_W-1:0]       from_f, to_f;
	logic signed [COST_FIELD_W-1:0] cost_f;
	logic signed [COST_BITS-1:0]   cost_sx;
	logic [COST_BITS-1:0]          cost_mag;
	logic                          from_ok, to_ok;
	logic [NW-1:0]                 from_idx, to_idx;
	logic                          run_go;
	edge_cmd_t                     ecmd;
	logic                          e_busy, e_present;
	logic [COST_BITS-1:0]          e_cost;

	logic [CW-1:0]                 cnt_q;
	logic [NW-1:0]                 cnt_idx;
	logic                          pass_end, out_last;
	logic [NW-1:0]                 cur_q;
	logic [DIST_W-1:0]             cur_dist_q;
	logic [NW-1:0]                 best_q, best_nx;
	logic [DIST_W-1:0]             best_dist_q, best_dist_nx;
	logic                          have_best_q, have_best_nx;
	logic [MAX_NODES-1:0]          reached_q, settled_q;
	logic                          vld_s1;
	logic [NW-1:0]                 j_s1;

	logic [DMW-1:0]                dmem [1 << NW];
	logic [DMW-1:0]                drd_q;
	logic [DIST_W-1:0]             rd_dist;
	logic [NW-1:0]                 rd_pred;
	logic [SW-1:0]                 sum;
	logic [DIST_W-1:0]             nd, new_dist;
	logic                          improve, new_reached, cand;
	logic                          dm_we;
	logic [NW-1:0]                 dm_waddr;
	logic [DMW-1:0]                dm_wdata;

	logic [NODE_FIELD_W-1:0]       out_node_q, out_pred_q;
	logic [DIST_W-1:0]             out_dist_q;
	logic                          out_reach_q, out_last_q;

	assign from_f   = s_tdata[3:0];
	assign to_f     = s_tdata[7:4];
	assign cost_f   = s_tdata[23:8];
	assign cost_sx  = COST_BITS'(cost_f);
	assign cost_mag = cost_sx[COST_BITS-1] ? $unsigned(-cost_sx) : $unsigned(cost_sx);
	assign from_ok  = 32'(from_f) < MAX_NODES;
	assign to_ok    = 32'(to_f) < MAX_NODES;
	assign from_idx = NW'(from_f);
	assign to_idx   = NW'(to_f);

	assign cnt_idx  = cnt_q[NW-1:0];
	assign pass_end = cnt_q == CW'(MAX_NODES);
	assign out_last = cnt_q == CW'(MAX_NODES - 1);

	ssp_edge_store #(
		.MAX_NODES (MAX_NODES),
		.COST_BITS (COST_BITS)
	) u_edges (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (ecmd),
		.wr_row     (from_idx),
		.wr_col     (to_idx),
		.wr_cost    (cost_mag),
		.rd_row     (cur_q),
		.rd_col     (cnt_idx),
		.busy       (e_busy),
		.rd_present (e_present),
		.rd_cost    (e_cost)
	);

	// Relax the edge to node j and fold the updated node into the selection.
	always_comb begin
		rd_dist     = drd_q[NW +: DIST_W];
		rd_pred     = drd_q[NW-1:0];
		sum         = SW'(cur_dist_q) + SW'(e_cost);
		nd          = (sum > SW'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
		improve     = vld_s1 && e_present && !settled_q[j_s1] &&
		              (!reached_q[j_s1] || nd < rd_dist);
		new_reached = reached_q[j_s1] || improve;
		new_dist    = improve ? nd : rd_dist;
		cand        = vld_s1 && new_reached && !settled_q[j_s1] &&
		              (!have_best_q || new_dist < best_dist_q);
		best_nx      = cand ? j_s1 : best_q;
		best_dist_nx = cand ? new_dist : best_dist_q;
		have_best_nx = have_best_q || cand;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && s_tuser == MODE_RUN) begin
					state_nx = from_ok ? ST_RELAX : ST_OUT_RD;
				end
			end
			ST_RELAX: begin
				if (pass_end && !have_best_nx) state_nx = ST_OUT_RD;
			end
			ST_OUT_RD: state_nx = ST_OUT_LD;
			ST_OUT_LD: state_nx = ST_OUT_WAIT;
			ST_OUT_WAIT: begin
				if (m_tready) state_nx = out_last ? ST_IDLE : ST_OUT_RD;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = (state_q == ST_IDLE) && !e_busy;
		m_tvalid   = state_q == ST_OUT_WAIT;
		accept     = s_tvalid && s_tready;
		run_go     = accept && s_tuser == MODE_RUN && from_ok;
		ecmd.clear = accept && s_tuser == MODE_CLEAR;
		ecmd.add   = accept && s_tuser == MODE_ADD && from_ok && to_ok &&
		             from_f != to_f;
		dm_we      = run_go || improve;
		dm_waddr   = run_go ? from_idx : j_s1;
		dm_wdata   = run_go ? '0 : {nd, cur_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			have_best_q <= 1'b0;
			reached_q   <= '0;
			settled_q   <= '0;
			vld_s1      <= 1'b0;
		end else begin
			state_q <= state_nx;
			vld_s1  <= (state_q == ST_RELAX) && !pass_end;
			case (state_q)
				ST_IDLE: begin
					if (accept && s_tuser == MODE_RUN) begin
						cnt_q       <= '0;
						have_best_q <= 1'b0;
						reached_q   <= from_ok ? (MAX_NODES'(1) << from_idx) : '0;
						settled_q   <= from_ok ? (MAX_NODES'(1) << from_idx) : '0;
					end
				end
				ST_RELAX: begin
					if (improve) reached_q[j_s1] <= 1'b1;
					if (pass_end) begin
						cnt_q       <= '0;
						have_best_q <= 1'b0;
						if (have_best_nx) settled_q[best_nx] <= 1'b1;
					end else begin
						cnt_q       <= cnt_q + 1'b1;
						have_best_q <= have_best_nx;
					end
				end
				ST_OUT_WAIT: begin
					if (m_tready) cnt_q <= cnt_q + 1'b1;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		j_s1 <= cnt_idx;
		if (run_go) begin
			cur_q      <= from_idx;
			cur_dist_q <= '0;
		end else if (state_q == ST_RELAX) begin
			best_q      <= best_nx;
			best_dist_q <= best_dist_nx;
			if (pass_end && have_best_nx) begin
				cur_q      <= best_nx;
				cur_dist_q <= best_dist_nx;
			end
		end
		if (state_q == ST_OUT_LD) begin
			out_node_q  <= NODE_FIELD_W'(cnt_idx);
			out_reach_q <= reached_q[cnt_idx];
			out_dist_q  <= reached_q[cnt_idx] ? rd_dist : '0;
			out_pred_q  <= reached_q[cnt_idx] ? NODE_FIELD_W'(rd_pred) : '0;
			out_last_q  <= out_last;
		end
	end

	always_ff @(posedge clk) begin
		if (dm_we) dmem[dm_waddr] <= dm_wdata;
		drd_q <= dmem[cnt_idx];
	end

	assign m_tdata = {4'b0, out_pred_q, out_dist_q, out_node_q};
	assign m_tuser = out_reach_q;
	assign m_tlast = out_last_q;

endmodule
